@@ sv/mte_pkg.sv @@
`default_nettype none
package mte_pkg;

  localparam int unsigned MaxSyms       = 6;
  localparam int unsigned CountWidth    = $clog2(MaxSyms + 1);
  localparam int unsigned DefQueueDepth = 2;

  localparam logic [1:0] SYM_DOT  = 2'd0;
  localparam logic [1:0] SYM_DASH = 2'd1;
  localparam logic [1:0] SYM_GAP  = 2'd2;

  localparam logic [7:0] LEAD_BYTE   = 8'hC3;
  localparam logic [7:0] CASE_OFFSET = 8'd32;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_UC_A   = 8'h41;
  localparam logic [7:0] CHAR_UC_Z   = 8'h5A;
  localparam logic [7:0] CHAR_LC_A   = 8'h61;
  localparam logic [7:0] CHAR_LC_Z   = 8'h7A;

  // Second bytes of the Swedish letters, upper and lower case
  localparam logic [7:0] ARING_UC = 8'h85;
  localparam logic [7:0] ARING_LC = 8'hA5;
  localparam logic [7:0] ADIA_UC  = 8'h84;
  localparam logic [7:0] ADIA_LC  = 8'hA4;
  localparam logic [7:0] ODIA_UC  = 8'h96;
  localparam logic [7:0] ODIA_LC  = 8'hB6;

  // Code numbers past Z
  localparam logic [4:0] IDX_ARING = 5'd26;
  localparam logic [4:0] IDX_ADIA  = 5'd27;
  localparam logic [4:0] IDX_ODIA  = 5'd28;

  // One request for the back end: symbols in emit order, slot 0 first
  typedef struct packed {
    logic [CountWidth-1:0]       count;
    logic [MaxSyms-1:0][1:0]     syms;
  } job_t;

  // len elements, dash bits left aligned (bit 4 is the first element), then a gap
  function automatic job_t build_job(input logic [2:0] len, input logic [4:0] dash);
    job_t j;
    j.count = CountWidth'(len) + CountWidth'(1);
    for (int i = 0; i < MaxSyms; i++) begin
      if (i < 5 && 3'(i) < len) begin
        j.syms[i] = dash[4 - i] ? SYM_DASH : SYM_DOT;
      end else if (3'(i) == len) begin
        j.syms[i] = SYM_GAP;
      end else begin
        j.syms[i] = SYM_GAP;
      end
    end
    return j;
  endfunction

  function automatic job_t space_job();
    job_t j;
    j.count = CountWidth'(2);
    for (int i = 0; i < MaxSyms; i++) begin
      j.syms[i] = SYM_GAP;
    end
    return j;
  endfunction

  function automatic job_t letter_job(input logic [4:0] idx);
    job_t j;
    case (idx)
      5'd0:    j = build_job(3'd2, 5'b01000);  // A .-
      5'd1:    j = build_job(3'd4, 5'b10000);  // B -...
      5'd2:    j = build_job(3'd4, 5'b10100);  // C -.-.
      5'd3:    j = build_job(3'd3, 5'b10000);  // D -..
      5'd4:    j = build_job(3'd1, 5'b00000);  // E .
      5'd5:    j = build_job(3'd4, 5'b00100);  // F ..-.
      5'd6:    j = build_job(3'd3, 5'b11000);  // G --.
      5'd7:    j = build_job(3'd4, 5'b00000);  // H ....
      5'd8:    j = build_job(3'd2, 5'b00000);  // I ..
      5'd9:    j = build_job(3'd4, 5'b01110);  // J .---
      5'd10:   j = build_job(3'd3, 5'b10100);  // K -.-
      5'd11:   j = build_job(3'd4, 5'b01000);  // L .-..
      5'd12:   j = build_job(3'd2, 5'b11000);  // M --
      5'd13:   j = build_job(3'd2, 5'b10000);  // N -.
      5'd14:   j = build_job(3'd3, 5'b11100);  // O ---
      5'd15:   j = build_job(3'd4, 5'b01100);  // P .--.
      5'd16:   j = build_job(3'd4, 5'b11010);  // Q --.-
      5'd17:   j = build_job(3'd3, 5'b01000);  // R .-.
      5'd18:   j = build_job(3'd3, 5'b00000);  // S ...
      5'd19:   j = build_job(3'd1, 5'b10000);  // T -
      5'd20:   j = build_job(3'd3, 5'b00100);  // U ..-
      5'd21:   j = build_job(3'd4, 5'b00010);  // V ...-
      5'd22:   j = build_job(3'd3, 5'b01100);  // W .--
      5'd23:   j = build_job(3'd4, 5'b10010);  // X -..-
      5'd24:   j = build_job(3'd4, 5'b10110);  // Y -.--
      5'd25:   j = build_job(3'd4, 5'b11000);  // Z --..
      5'd26:   j = build_job(3'd5, 5'b01101);  // A-ring .--.-
      5'd27:   j = build_job(3'd4, 5'b01010);  // A-diaeresis .-.-
      5'd28:   j = build_job(3'd4, 5'b11100);  // O-diaeresis ---.
      default: j = build_job(3'd0, 5'b00000);
    endcase
    return j;
  endfunction

endpackage
`default_nettype wire

@@ sv/mte_front.sv @@
`default_nettype none
module mte_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [7:0]    in_text_byte,
  input  wire logic          q_full,
  output logic               in_stall,
  output logic               push,
  output mte_pkg::job_t      push_job
);

  logic       lead_pending_r, lead_pending_nxt;
  logic       accept;
  logic [7:0] folded;
  logic [4:0] letter_off;
  logic       is_aring, is_adia, is_odia;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    is_aring = lead_pending_r &&
               (in_text_byte == mte_pkg::ARING_UC || in_text_byte == mte_pkg::ARING_LC);
    is_adia  = lead_pending_r &&
               (in_text_byte == mte_pkg::ADIA_UC || in_text_byte == mte_pkg::ADIA_LC);
    is_odia  = lead_pending_r &&
               (in_text_byte == mte_pkg::ODIA_UC || in_text_byte == mte_pkg::ODIA_LC);

    if (in_text_byte >= mte_pkg::CHAR_LC_A && in_text_byte <= mte_pkg::CHAR_LC_Z) begin
      folded = in_text_byte - mte_pkg::CASE_OFFSET;
    end else begin
      folded = in_text_byte;
    end
    // A..Z share their upper bits, so the low five bits give the code number
    letter_off = folded[4:0] - mte_pkg::CHAR_UC_A[4:0];

    push     = 1'b0;
    push_job = mte_pkg::space_job();
    if (is_aring) begin
      push     = accept;
      push_job = mte_pkg::letter_job(mte_pkg::IDX_ARING);
    end else if (is_adia) begin
      push     = accept;
      push_job = mte_pkg::letter_job(mte_pkg::IDX_ADIA);
    end else if (is_odia) begin
      push     = accept;
      push_job = mte_pkg::letter_job(mte_pkg::IDX_ODIA);
    end else if (folded >= mte_pkg::CHAR_UC_A && folded <= mte_pkg::CHAR_UC_Z) begin
      push     = accept;
      push_job = mte_pkg::letter_job(letter_off);
    end else if (in_text_byte == mte_pkg::CHAR_SPACE) begin
      push     = accept;
      push_job = mte_pkg::space_job();
    end

    // Any accepted byte drops a held lead; only a fresh lead byte sets it
    lead_pending_nxt = accept ? (in_text_byte == mte_pkg::LEAD_BYTE) : lead_pending_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_pending_r <= 1'b0;
    end else begin
      lead_pending_r <= lead_pending_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/mte_queue.sv @@
`default_nettype none
module mte_queue #(
  parameter int unsigned Depth = mte_pkg::DefQueueDepth
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  mte_pkg::job_t      push_job,
  input  wire logic          pop,
  output logic               full,
  output logic               not_empty,
  output mte_pkg::job_t      head_job
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);

  mte_pkg::job_t         entries_r [Depth];
  logic [PtrWidth-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrWidth-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntWidth-1:0]   fill_r, fill_nxt;

  assign full      = (fill_r == CntWidth'(Depth));
  assign not_empty = (fill_r != '0);
  assign head_job  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrWidth'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrWidth'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + CntWidth'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CntWidth'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

@@ sv/mte_back.sv @@
`default_nettype none
module mte_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_not_empty,
  input  mte_pkg::job_t      q_head,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         out_symbol,
  output logic               out_last
);

  localparam int unsigned CW = mte_pkg::CountWidth;

  logic [CW-1:0]                   remain_r, remain_nxt;
  logic [mte_pkg::MaxSyms-1:0][1:0] syms_r, syms_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [1:0]                      out_symbol_r, out_symbol_nxt;
  logic                            out_last_r, out_last_nxt;
  logic                            busy, emit, finishing, load;

  assign busy       = (remain_r != '0);
  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

  always_comb begin
    // Advance one symbol whenever the output register is free or drains
    emit      = busy && (!out_valid_r || !out_stall);
    finishing = emit && (remain_r == CW'(1));
    load      = !busy || finishing;
    pop       = load && q_not_empty;

    out_valid_nxt  = out_valid_r && out_stall;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    remain_nxt     = remain_r;
    syms_nxt       = syms_r;

    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_symbol_nxt = syms_r[0];
      out_last_nxt   = finishing;
      remain_nxt     = remain_r - CW'(1);
      syms_nxt       = {mte_pkg::SYM_GAP, syms_r[mte_pkg::MaxSyms-1:1]};
    end
    if (pop) begin
      remain_nxt = q_head.count;
      syms_nxt   = q_head.syms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    syms_r       <= syms_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule
`default_nettype wire

@@ sv/utf8_text_to_morse_encoder.sv @@
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_stall    in_text_byte[7:0] (one UTF-8 byte)
// out_      output     out_valid/out_stall  out_symbol[1:0] (0 dot, 1 dash, 2 gap), out_last
//
// A byte is classified in its accept cycle and its request is written into the queue;
// with the emitter idle, it moves from the queue into the emitter, whose first symbol
// sets out_valid in the output register. The emitter sends one symbol per cycle while
// out_stall is low; a request holds 2 to 6 symbols, a byte with no symbols writes no
// request, and requests waiting in the queue run back to back with no bubble between them.
// Reset (rst_n low, synchronous) clears the held lead byte, the queue and the output.
// out_stall holds the output register; the emitter and then the queue fill up behind it,
// and in_stall rises once the queue is full.
`default_nettype none
module utf8_text_to_morse_encoder #(
  parameter int unsigned QueueDepth = mte_pkg::DefQueueDepth  // 2 to 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_text_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_symbol,
  output logic             out_last
);

  // Request path: classifier -> queue -> emitter
  logic          q_full;
  logic          q_not_empty;
  logic          push;
  logic          pop;
  mte_pkg::job_t push_job;
  mte_pkg::job_t head_job;

  // Front end: fold case, track the lead byte, turn each letter or space into a request
  mte_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_text_byte (in_text_byte),
    .q_full       (q_full),
    .in_stall     (in_stall),
    .push         (push),
    .push_job     (push_job)
  );

  // Short queue decouples byte intake from symbol output
  mte_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  // Back end: shift out one symbol per cycle into the output register unless out_stall holds it
  mte_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (head_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_symbol  (out_symbol),
    .out_last    (out_last)
  );

endmodule
`default_nettype wire

@@ sv/mte_checker.sv @@
`default_nettype none
module mte_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_symbol,
  input wire logic       out_last
);

  // Symbol code 3 is never driven
  a_sym_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_symbol == mte_pkg::SYM_DOT || out_symbol == mte_pkg::SYM_DASH ||
                   out_symbol == mte_pkg::SYM_GAP))
    else $error("illegal symbol code");

  // Every request closes on a gap
  a_last_is_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_symbol == mte_pkg::SYM_GAP)
    else $error("last symbol is not a gap");

  // Dots and dashes are never final, and the rest of the request follows at once
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_symbol != mte_pkg::SYM_GAP |=> out_valid)
    else $error("bubble inside a letter");

  // Reset empties the output
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_symbol) && $stable(out_last))
    else $error("stalled output changed");

endmodule

bind utf8_text_to_morse_encoder mte_checker u_mte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_symbol (out_symbol),
  .out_last   (out_last)
);
`default_nettype wire
